// File: rtl/core/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants for the pump run supervisor
// Beat layouts for the tick and result channels, mode codes, register
// indexes and fixed timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

   // pumps watched for end of travel and width of their step counts
   localparam int PUMP_COUNT  = 5;
   localparam int PUMP_IDX_W  = 3;
   localparam int STEP_W      = 24;
   localparam int STEP_BITS   = 24;
   localparam logic [STEP_W-1:0] STEP_MASK =
      STEP_W'((64'd1 << STEP_BITS) - 64'd1);

   // fault LED half period in ticks
   localparam logic [7:0] BLINK_TICKS = 8'd200;
   localparam logic [7:0] HOLD_MAX    = 8'd255;
   localparam logic [9:0] CTRL_MAX    = 10'd1023;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_PERIOD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_STROKE_STEPS = 2'd2;

   // register reset values
   localparam logic [7:0]        DEBOUNCE_RESET    = 8'd20;
   localparam logic [9:0]        PERIOD_RESET      = 10'd20;
   localparam logic [STEP_W-1:0] FULL_STROKE_RESET = 24'd100000;

   // supervisor mode
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_FAULT = 2'd2
   } mode_type;

   // one tick beat
   typedef struct packed {
      logic              switch_raw;
      logic [STEP_W-1:0] steps_in_a;
      logic [STEP_W-1:0] steps_in_b;
      logic [STEP_W-1:0] steps_out_a;
      logic [STEP_W-1:0] steps_out_b;
      logic [STEP_W-1:0] steps_out_c;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [1:0]            mode;
      logic                  motor_enable;
      logic                  run_led;
      logic                  fault_led;
      logic [PUMP_IDX_W-1:0] fault_pump;
      logic                  clear_steps;
      logic                  arm_ready;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/pump_run_supervisor.sv
// ----------------------------------------------------------------------------
// pump_run_supervisor: run-switch supervisor for a multi-pump syringe rig
//
// Each req beat is one millisecond tick carrying the raw run-switch level
// and the step counts of the pumps; each tick gives exactly one rsp beat
// with the mode, motor enable, LEDs, faulted pump, step-clear pulse and
// arm-ready flag.
// Both channels use valid/ready. A tick is captured in an input register
// and evaluated against the supervisor state in the next stage, whose
// result sits in an output register; rsp_valid comes from that output
// register, and one tick per cycle is sustained while the receiver keeps
// rsp_ready high. The state update (debounce, inhibit, mode, travel check,
// blink) is combinational, between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and req_ready drops only while both are occupied and rsp_ready
// is low.
// The csr port writes debounce_ticks, control_period and full_stroke_steps;
// the user must make writes only while no tick is in flight; the block does not enforce it.
// Synchronous reset clears both pipeline stages, restores the register
// defaults and puts the supervisor in idle with the arm inhibit set.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_run_supervisor
   import prs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tick channel
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_type               req_data,
   // result channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_type               rsp_data,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [7:0]        debounce_ff, debounce_in;
   logic [9:0]        period_ff, period_in;
   logic [STEP_W-1:0] stroke_ff, stroke_in;

   // pipeline registers
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // supervisor state
   logic                  last_level_ff, last_level_in;
   logic                  stable_ff, stable_in;
   logic                  settled_ff, settled_in;
   logic [7:0]            hold_ff, hold_in;
   logic                  inhibit_ff, inhibit_in;
   mode_type              mode_ff, mode_in;
   logic [9:0]            ctrl_ff, ctrl_in;
   logic [7:0]            blink_ff, blink_in;
   logic                  light_ff, light_in;
   logic [PUMP_IDX_W-1:0] fidx_ff, fidx_in;

   // intermediate terms
   logic                  advance;
   logic                  step_en;
   logic                  want_run;
   logic                  clear_pulse;
   logic                  light_mid;
   mode_type              mode_mid;
   logic [7:0]            hold_inc;
   logic [9:0]            ctrl_inc;
   logic [7:0]            blink_inc;
   logic                  check_now;
   logic [STEP_W-1:0]     steps [PUMP_COUNT];
   logic                  any_hit;
   logic [PUMP_IDX_W-1:0] hit_idx;

   // handshake: result stage moves when empty or drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign step_en   = in_valid_ff && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // pipeline next values
   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      in_data_in   = (req_valid && req_ready) ? req_data : in_data_ff;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   // configuration writes
   always_comb begin
      debounce_in = debounce_ff;
      period_in   = period_ff;
      stroke_in   = stroke_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS:    debounce_in = csr_wdata[7:0];
            CSR_CONTROL_PERIOD:    period_in   = csr_wdata[9:0];
            CSR_FULL_STROKE_STEPS: stroke_in   = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // debounce and arm inhibit
   always_comb begin
      last_level_in = last_level_ff;
      stable_in     = stable_ff;
      settled_in    = settled_ff;
      hold_inc      = (hold_ff == HOLD_MAX) ? HOLD_MAX : hold_ff + 8'd1;
      hold_in       = hold_ff;
      if (in_data_ff.switch_raw != last_level_ff) begin
         last_level_in = in_data_ff.switch_raw;
         hold_in       = '0;
      end else begin
         hold_in = hold_inc;
         if (hold_inc >= debounce_ff) begin
            stable_in  = in_data_ff.switch_raw;
            settled_in = 1'b1;
         end
      end
      want_run   = !stable_in;
      inhibit_in = (settled_in && !want_run) ? 1'b0 : inhibit_ff;
   end

   // step counts in pump order, masked to the count width
   always_comb begin
      steps[0] = in_data_ff.steps_in_a  & STEP_MASK;
      steps[1] = in_data_ff.steps_in_b  & STEP_MASK;
      steps[2] = in_data_ff.steps_out_a & STEP_MASK;
      steps[3] = in_data_ff.steps_out_b & STEP_MASK;
      steps[4] = in_data_ff.steps_out_c & STEP_MASK;
   end

   // first pump at end of travel
   always_comb begin
      any_hit = 1'b0;
      hit_idx = '0;
      for (int i = PUMP_COUNT - 1; i >= 0; i--) begin
         if (steps[i] >= stroke_ff) begin
            any_hit = 1'b1;
            hit_idx = PUMP_IDX_W'(i);
         end
      end
   end

   // control period timer
   always_comb begin
      ctrl_inc  = (ctrl_ff == CTRL_MAX) ? CTRL_MAX : ctrl_ff + 10'd1;
      check_now = (ctrl_inc >= period_ff);
      ctrl_in   = check_now ? '0 : ctrl_inc;
   end

   // mode next state: switch transitions, then travel check
   always_comb begin
      mode_mid    = MODE_IDLE;
      clear_pulse = 1'b0;
      light_mid   = light_ff;
      case (mode_ff)
         MODE_RUN: begin
            mode_mid = want_run ? MODE_RUN : MODE_IDLE;
         end
         MODE_FAULT: begin
            if (want_run) begin
               mode_mid = MODE_FAULT;
            end else begin
               clear_pulse = 1'b1;
               light_mid   = 1'b0;
            end
         end
         default: begin
            mode_mid = (want_run && !inhibit_in) ? MODE_RUN : MODE_IDLE;
         end
      endcase
      mode_in = mode_mid;
      fidx_in = fidx_ff;
      if (check_now && mode_mid == MODE_RUN && any_hit) begin
         mode_in = MODE_FAULT;
         fidx_in = hit_idx;
      end
   end

   // fault blink
   always_comb begin
      blink_inc = (blink_ff == HOLD_MAX) ? HOLD_MAX : blink_ff + 8'd1;
      blink_in  = blink_inc;
      light_in  = light_mid;
      if (mode_in == MODE_FAULT && blink_inc >= BLINK_TICKS) begin
         blink_in = '0;
         light_in = !light_mid;
      end
   end

   // result outputs
   always_comb begin
      rsp_data_in.mode         = mode_in;
      rsp_data_in.motor_enable = (mode_in == MODE_RUN);
      rsp_data_in.run_led      = (mode_in == MODE_RUN);
      rsp_data_in.fault_led    = light_in;
      rsp_data_in.fault_pump   = (mode_in == MODE_FAULT) ? fidx_in : '0;
      rsp_data_in.clear_steps  = clear_pulse;
      rsp_data_in.arm_ready    = !inhibit_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         debounce_ff   <= DEBOUNCE_RESET;
         period_ff     <= PERIOD_RESET;
         stroke_ff     <= FULL_STROKE_RESET;
         last_level_ff <= 1'b1;
         stable_ff     <= 1'b1;
         settled_ff    <= 1'b0;
         hold_ff       <= '0;
         inhibit_ff    <= 1'b1;
         mode_ff       <= MODE_IDLE;
         ctrl_ff       <= '0;
         blink_ff      <= '0;
         light_ff      <= 1'b0;
         fidx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         debounce_ff  <= debounce_in;
         period_ff    <= period_in;
         stroke_ff    <= stroke_in;
         if (step_en) begin
            last_level_ff <= last_level_in;
            stable_ff     <= stable_in;
            settled_ff    <= settled_in;
            hold_ff       <= hold_in;
            inhibit_ff    <= inhibit_in;
            mode_ff       <= mode_in;
            ctrl_ff       <= ctrl_in;
            blink_ff      <= blink_in;
            light_ff      <= light_in;
            fidx_ff       <= fidx_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (step_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/tb_pump_run_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pump_run_supervisor: self-checking bench for the pump run supervisor
// Ticks are driven from a queue through a valid/ready driver. A predictor
// keeps its own copy of the supervisor state and computes the expected
// status beat for every accepted tick. A monitor compares each result beat
// field by field. A directed opening covers field extremes, arming, fault
// entry and fault acknowledge. Random phases then run under several
// register settings, including zero values and the full-scale debounce and stroke.
// ----------------------------------------------------------------------------
module tb_pump_run_supervisor;
   import prs_pkg::*;

   localparam int PUMPS         = 5;
   localparam int BLINK_HALF    = 200;
   localparam int PIPE_CYCLES   = 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_QUIET  = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // ticks waiting to be driven and status beats still to arrive
   req_type pending_ticks[$];
   rsp_type expected_status[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int status_seen = 0;
   int quiet_cycles = 0;

   // predictor copy of the registers
   logic [7:0]  cfg_debounce = 8'd20;
   logic [9:0]  cfg_period   = 10'd20;
   logic [23:0] cfg_full     = 24'd100000;

   // predictor copy of the supervisor state
   logic        sv_last     = 1'b1;
   logic        sv_stable   = 1'b1;
   logic        sv_settled  = 1'b0;
   logic [7:0]  sv_hold     = 8'd0;
   logic        sv_inhibit  = 1'b1;
   mode_type    sv_mode     = MODE_IDLE;
   logic [9:0]  sv_ctrl     = 10'd0;
   logic [7:0]  sv_blink    = 8'd0;
   logic        sv_light    = 1'b0;
   logic [2:0]  sv_fidx     = 3'd0;

   pump_run_supervisor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // advance the supervisor by one tick and return its status beat
   function automatic rsp_type supervise_tick(req_type t);
      logic [23:0] steps [PUMPS];
      logic        want_run;
      logic        clr;
      logic        found;
      rsp_type     s;
      steps[0] = t.steps_in_a;
      steps[1] = t.steps_in_b;
      steps[2] = t.steps_out_a;
      steps[3] = t.steps_out_b;
      steps[4] = t.steps_out_c;
      clr = 1'b0;
      found = 1'b0;

      // debounce: a change restarts the hold, a repeat counts towards it
      if (t.switch_raw != sv_last) begin
         sv_last = t.switch_raw;
         sv_hold = 8'd0;
      end else begin
         if (sv_hold != 8'd255) sv_hold = sv_hold + 8'd1;
         if (sv_hold >= cfg_debounce) begin
            sv_stable = t.switch_raw;
            sv_settled = 1'b1;
         end
      end
      want_run = ~sv_stable;

      // inhibit only lifts on a settled open switch
      if (sv_settled && !want_run) sv_inhibit = 1'b0;

      case (sv_mode)
         MODE_RUN: begin
            if (!want_run) sv_mode = MODE_IDLE;
         end
         MODE_FAULT: begin
            if (!want_run) begin
               clr = 1'b1;
               sv_mode = MODE_IDLE;
               sv_light = 1'b0;
            end
         end
         default: begin
            sv_mode = MODE_IDLE;
            if (want_run && !sv_inhibit) sv_mode = MODE_RUN;
         end
      endcase

      // end-of-travel check, first pump in order wins
      if (sv_ctrl != 10'd1023) sv_ctrl = sv_ctrl + 10'd1;
      if (sv_ctrl >= cfg_period) begin
         sv_ctrl = 10'd0;
         if (sv_mode == MODE_RUN) begin
            for (int i = 0; i < PUMPS; i++) begin
               if (!found && steps[i] >= cfg_full) begin
                  found = 1'b1;
                  sv_mode = MODE_FAULT;
                  sv_fidx = 3'(i);
               end
            end
         end
      end

      // fault LED blink
      if (sv_blink != 8'd255) sv_blink = sv_blink + 8'd1;
      if (sv_mode == MODE_FAULT && sv_blink >= BLINK_HALF) begin
         sv_blink = 8'd0;
         sv_light = ~sv_light;
      end

      s.mode         = sv_mode;
      s.motor_enable = (sv_mode == MODE_RUN);
      s.run_led      = (sv_mode == MODE_RUN);
      s.fault_led    = sv_light;
      s.fault_pump   = (sv_mode == MODE_FAULT) ? sv_fidx : 3'd0;
      s.clear_steps  = clr;
      s.arm_ready    = ~sv_inhibit;
      return s;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      if (mismatch_count < REPORT_QUIET)
         $display("[%0t] status beat %0d, %s: expected %0d, got %0d",
                  $time, status_seen, what, want, got);
      mismatch_count++;
   endtask

   function automatic req_type make_tick(logic raw, logic [23:0] a, b, c, d, e);
      req_type t;
      t.switch_raw  = raw;
      t.steps_in_a  = a;
      t.steps_in_b  = b;
      t.steps_out_a = c;
      t.steps_out_b = d;
      t.steps_out_c = e;
      return t;
   endfunction

   // step count: mostly short of full stroke, now and then at or past it
   function automatic logic [23:0] pick_steps(int odds);
      int unsigned full;
      full = cfg_full;
      if ($urandom_range(1, odds) != 1)
         return (full == 0) ? 24'($urandom) : 24'($urandom_range(0, full - 1));
      case ($urandom_range(0, 2))
         0:       return 24'(full);
         1:       return (full == 0) ? 24'd0 : 24'(full - 1);
         default: return 24'($urandom_range(full, 24'hFFFFFF));
      endcase
   endfunction

   // switch held in segments around the debounce time, some noisy,
   // some long enough for the fault LED to blink
   task automatic add_random_ticks(int count);
      int      added;
      int      seg_len;
      int      odds;
      int      pick;
      bit      noisy;
      logic    level;
      req_type t;
      added = 0;
      level = 1'b1;
      while (added < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) seg_len = $urandom_range(1, int'(cfg_debounce) + 1);
         else if (pick < 4) seg_len = int'(cfg_debounce) + $urandom_range(220, 320);
         else seg_len = int'(cfg_debounce) + $urandom_range(2, 40);
         odds = ($urandom_range(0, 2) == 0) ? 12 : 80;
         noisy = ($urandom_range(0, 2) == 0);
         for (int j = 0; j < seg_len && added < count; j++) begin
            t.switch_raw  = (noisy && $urandom_range(0, 29) == 0) ? ~level : level;
            t.steps_in_a  = pick_steps(odds);
            t.steps_in_b  = pick_steps(odds);
            t.steps_out_a = pick_steps(odds);
            t.steps_out_b = pick_steps(odds);
            t.steps_out_c = pick_steps(odds);
            pending_ticks.push_back(t);
            added++;
         end
         level = ~level;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_status.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // new register setting, only once the pipeline has emptied
   task automatic configure(logic [7:0] debounce, logic [9:0] period, logic [23:0] full);
      wait_drained();
      repeat (PIPE_CYCLES) @(posedge clock);
      write_reg(CSR_DEBOUNCE_TICKS, CSR_DATA_W'(debounce));
      write_reg(CSR_CONTROL_PERIOD, CSR_DATA_W'(period));
      write_reg(CSR_FULL_STROKE_STEPS, full);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_debounce = debounce;
      cfg_period   = period;
      cfg_full     = full;
      @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct = 17;
            recv_idle_pct = 49;
         end
         1: begin
            send_idle_pct = 49;
            recv_idle_pct = 17;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // tick driver; the predictor runs on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_status.push_back(supervise_tick(req_data));
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_ticks.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // status monitor and receiver stalls
   always @(posedge clock) begin : status_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected beat", 0, rsp_data);
            end else begin
               want = expected_status.pop_front();
               if (rsp_data.mode !== want.mode)
                  report_mismatch("mode", want.mode, rsp_data.mode);
               if (rsp_data.motor_enable !== want.motor_enable)
                  report_mismatch("motor_enable", want.motor_enable, rsp_data.motor_enable);
               if (rsp_data.run_led !== want.run_led)
                  report_mismatch("run_led", want.run_led, rsp_data.run_led);
               if (rsp_data.fault_led !== want.fault_led)
                  report_mismatch("fault_led", want.fault_led, rsp_data.fault_led);
               if (rsp_data.fault_pump !== want.fault_pump)
                  report_mismatch("fault_pump", want.fault_pump, rsp_data.fault_pump);
               if (rsp_data.clear_steps !== want.clear_steps)
                  report_mismatch("clear_steps", want.clear_steps, rsp_data.clear_steps);
               if (rsp_data.arm_ready !== want.arm_ready)
                  report_mismatch("arm_ready", want.arm_ready, rsp_data.arm_ready);
            end
            status_seen++;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: too long without a beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_idling(0);

      // reset settings: field extremes and a switch too short to settle
      pending_ticks.push_back(make_tick(1'b1, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));
      pending_ticks.push_back(make_tick(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                        24'hFFFFFF, 24'hFFFFFF));
      pending_ticks.push_back(make_tick(1'b0, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA,
                                        24'hAAAAAA, 24'hAAAAAA));
      pending_ticks.push_back(make_tick(1'b1, 24'h555555, 24'h555555, 24'h555555,
                                        24'h555555, 24'h555555));
      pending_ticks.push_back(make_tick(1'b0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));
      pending_ticks.push_back(make_tick(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                        24'hFFFFFF, 24'hFFFFFF));
      pending_ticks.push_back(make_tick(1'b0, 24'h123456, 24'h789ABC, 24'hDEF012,
                                        24'h345678, 24'h9ABCDE));
      pending_ticks.push_back(make_tick(1'b1, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0));

      // zero debounce and zero period: arm, run, fault, acknowledge
      configure(8'd0, 10'd0, 24'd100000);
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b0, 24'd99999, 24'd99999, 24'd99999,
                                        24'd99999, 24'd99999));
      pending_ticks.push_back(make_tick(1'b0, 24'd99999, 24'd99999, 24'd99999,
                                        24'd99999, 24'd100000));
      pending_ticks.push_back(make_tick(1'b0, 24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      // idle to run and straight into fault; lowest faulted pump reported
      pending_ticks.push_back(make_tick(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b0, 24'd99999, 24'd100000, 24'd0,
                                        24'hFFFFFF, 24'd0));
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      // plain run then open: back to idle without a clear pulse
      pending_ticks.push_back(make_tick(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      pending_ticks.push_back(make_tick(1'b1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));

      // zero full stroke: any check while running faults
      configure(8'd0, 10'd0, 24'd0);
      add_random_ticks(120);

      // longest debounce, check every tick, largest stroke
      configure(8'd255, 10'd1, 24'hFFFFFF);
      set_idling(1);
      add_random_ticks(400);

      // slowest check period
      configure(8'd0, 10'd1000, 24'($urandom));
      set_idling(2);
      add_random_ticks(250);

      // short timings with a small stroke: frequent faults and blinking
      configure(8'd2, 10'd3, 24'd4096);
      add_random_ticks(200);

      wait_drained();
      repeat (PIPE_CYCLES * 4) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
